[src/gss_pkg.sv]
// Shared types, constants and command formats of the Gray-Scott stencil engine.
`default_nettype none

package gss_pkg;

    // Default geometry and number format
    localparam int GRID_WIDTH_DEF          = 256;
    localparam int VALUE_FRACTION_BITS_DEF = 15;

    // Taps of one 3x3 window, read in raster order
    localparam int FETCH_TAPS = 9;

    // Coefficient reset values (Q2.14)
    localparam logic signed [15:0] CENTER_RESET   = -16'sd16384;
    localparam logic signed [15:0] CARDINAL_RESET = 16'sd3277;
    localparam logic signed [15:0] DIAGONAL_RESET = 16'sd819;
    localparam logic [14:0]        DIFF_A_RESET   = 15'd16384;
    localparam logic [14:0]        DIFF_B_RESET   = 15'd8192;
    localparam logic [14:0]        FEED_RESET     = 15'd901;
    localparam logic [14:0]        KILL_RESET     = 15'd1016;
    localparam logic [14:0]        DT_RESET       = 15'd16384;

    // Item kinds
    localparam logic MODE_DRAIN = 1'b1;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        REG_CENTER,
        REG_CARDINAL,
        REG_DIAGONAL,
        REG_DIFF_A,
        REG_DIFF_B,
        REG_FEED,
        REG_KILL,
        REG_TIME_STEP
    } reg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CALC,
        S_LOAD
    } state_t;

    // Datapath micro-steps; border cells run PASS then GRAY
    typedef enum logic [4:0] {
        ST_LAPC_A, ST_LAPE_A, ST_LAPD_A, ST_DIFH_A, ST_DIFL_A, ST_DIFS_A,
        ST_LAPC_B, ST_LAPE_B, ST_LAPD_B, ST_DIFH_B, ST_DIFL_B, ST_DIFS_B,
        ST_AB, ST_ABB, ST_FEED, ST_KILL,
        ST_DA, ST_TAH, ST_TAL, ST_NA,
        ST_DB, ST_TBH, ST_TBL, ST_NB,
        ST_GRAY, ST_PASS
    } step_t;

    // Commands from controller to datapath
    typedef struct packed {
        step_t      step;
        logic       calc;
        logic       tap_valid;
        logic [3:0] tap_idx;
        logic       load_out;
        logic       last;
    } cmd_t;

endpackage

`default_nettype wire

[src/gray_scott_stencil_step.sv]
// A cell word that frees no result is only accepted. A word that releases a result runs through
// the accept, the window fetch (9 reads over the single read port of the line stores plus
// the read latency), the 25 datapath steps around the shared multiplier for an interior cell
// or the PASS and GRAY steps for a border cell, and the load, which waits for a free output
// slot. One word is worked on at a time; the output register lets the next word in while a
// result waits. Reset clears the control state and loads the default coefficients; the line stores are not cleared.
`default_nettype none

module gray_scott_stencil_step import gss_pkg::*; #(
    parameter int GRID_WIDTH          = GRID_WIDTH_DEF,
    parameter int VALUE_FRACTION_BITS = VALUE_FRACTION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [15:0] a_in,
    input  wire logic [15:0] b_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] a_out,
    output logic      [15:0] b_out,
    output logic      [7:0]  gray_level,
    output logic             last_of_frame
);

    localparam int RingDepth = 2 * GRID_WIDTH + 3;
    localparam int RW = $clog2(RingDepth);

    cmd_t          cmd;
    logic          ram_we;
    logic [RW-1:0] ram_waddr;
    logic [RW-1:0] ram_raddr;
    logic [15:0]   a_tap;
    logic [15:0]   b_tap;

    gss_ctrl #(
        .GRID_WIDTH(GRID_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_raddr (ram_raddr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    gss_ram #(
        .WIDTH(16),
        .DEPTH(RingDepth)
    ) u_a_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (a_in),
        .raddr (ram_raddr),
        .rdata (a_tap)
    );

    gss_ram #(
        .WIDTH(16),
        .DEPTH(RingDepth)
    ) u_b_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (b_in),
        .raddr (ram_raddr),
        .rdata (b_tap)
    );

    gss_datapath #(
        .VALUE_FRACTION_BITS(VALUE_FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .a_tap         (a_tap),
        .b_tap         (b_tap),
        .a_out         (a_out),
        .b_out         (b_out),
        .gray_level    (gray_level),
        .last_of_frame (last_of_frame)
    );

    // Never overwrite a result word that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result loaded over a waiting word");

    // Store writes only with an accepted word
    a_write_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (in_ready && in_valid))
        else $error("line store written without an accepted word");

    // A result only appears after a load command
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("output valid without a load");

endmodule

`default_nettype wire

[src/gss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/gss_ctrl.sv]
// Controller: ring pointers, window fetch sequence, step sequencing and output handshake.
`default_nettype none

module gss_ctrl import gss_pkg::*; #(
    parameter int GRID_WIDTH = GRID_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic mode,
    output logic      ram_we,
    output logic [$clog2(2*GRID_WIDTH+3)-1:0] ram_waddr,
    output logic [$clog2(2*GRID_WIDTH+3)-1:0] ram_raddr,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    localparam int RingDepth = 2 * GRID_WIDTH + 3;
    localparam int RW = $clog2(RingDepth);
    localparam int PW = $clog2(RingDepth + 1);
    localparam int DW = PW + 1;
    localparam int CW = $clog2(GRID_WIDTH);
    localparam logic [3:0] FetchLast  = 4'(FETCH_TAPS);
    localparam logic [3:0] TapRowEnd0 = 4'd2;
    localparam logic [3:0] TapRowEnd1 = 4'd5;

    state_t        state_reg, state_next;
    step_t         step_reg, step_next;
    logic [RW-1:0] inpos_reg, inpos_next;
    logic [PW-1:0] pending_reg, pending_next;
    logic [RW-1:0] addr_reg, addr_next;
    logic [3:0]    k_reg, k_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          border_reg, border_next;
    logic          last_reg, last_next;
    logic          out_valid_reg, out_valid_next;
    logic          tap_valid_reg;
    logic [3:0]    tap_idx_reg;

    logic          accept;
    logic          slot_free;
    logic          do_emit;
    logic [RW-1:0] inpos_inc;
    logic [RW-1:0] pos_now;
    logic [PW-1:0] pend_cell;
    logic [PW-1:0] pend_now;
    logic [DW-1:0] head_d;
    logic [RW-1:0] head;
    logic [DW-1:0] base_d;
    logic [RW-1:0] base;
    logic [DW-1:0] addr_sum;
    logic [DW-1:0] addr_step;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Ring bookkeeping for the word being accepted
    always_comb
    begin
        inpos_inc = (inpos_reg == RW'(RingDepth - 1)) ? '0 : inpos_reg + 1'b1;
        pend_cell = (pending_reg < PW'(RingDepth)) ? pending_reg + 1'b1 : pending_reg;
        if (mode == MODE_DRAIN)
        begin
            pos_now  = inpos_reg;
            pend_now = pending_reg;
            do_emit  = (pending_reg != '0);
        end
        else
        begin
            pos_now  = inpos_inc;
            pend_now = pend_cell;
            do_emit  = (pend_cell > PW'(GRID_WIDTH + 1));
        end
        head_d = DW'(pos_now) - DW'(pend_now);
        head   = head_d[DW-1] ? RW'(head_d + DW'(RingDepth)) : RW'(head_d);
        base_d = DW'(head) - DW'(GRID_WIDTH + 1);
        base   = base_d[DW-1] ? RW'(base_d + DW'(RingDepth)) : RW'(base_d);
    end

    // Next fetch address: step one cell, or wrap to the next window row
    always_comb
    begin
        addr_step = (k_reg == TapRowEnd0 || k_reg == TapRowEnd1) ?
                    DW'(GRID_WIDTH - 2) : DW'(1);
        addr_sum  = DW'(addr_reg) + addr_step;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && do_emit)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (k_reg == FetchLast)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (step_reg == ST_GRAY)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        ram_we         = accept && (mode != MODE_DRAIN);
        ram_waddr      = inpos_reg;
        ram_raddr      = addr_reg;
        out_valid      = out_valid_reg;

        inpos_next     = inpos_reg;
        pending_next   = pending_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        border_next    = border_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd.step      = step_reg;
        cmd.calc      = 1'b0;
        cmd.tap_valid = tap_valid_reg;
        cmd.tap_idx   = tap_idx_reg;
        cmd.load_out  = 1'b0;
        cmd.last      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    inpos_next   = pos_now;
                    pending_next = pend_now;
                    if (do_emit)
                    begin
                        // Take the oldest pending cell and advance the raster position
                        pending_next = pend_now - 1'b1;
                        addr_next    = base;
                        k_next       = '0;
                        border_next  = (row_reg == '0) || (col_reg == '0) ||
                                       (row_reg == CW'(GRID_WIDTH - 1)) ||
                                       (col_reg == CW'(GRID_WIDTH - 1));
                        last_next    = (row_reg == CW'(GRID_WIDTH - 1)) &&
                                       (col_reg == CW'(GRID_WIDTH - 1));
                        if (col_reg == CW'(GRID_WIDTH - 1))
                        begin
                            col_next = '0;
                            row_next = (row_reg == CW'(GRID_WIDTH - 1)) ? '0 : row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                k_next    = k_reg + 1'b1;
                addr_next = (addr_sum >= DW'(RingDepth)) ?
                            RW'(addr_sum - DW'(RingDepth)) : RW'(addr_sum);
                step_next = border_reg ? ST_PASS : ST_LAPC_A;
            end
            S_CALC:
            begin
                cmd.calc  = 1'b1;
                step_next = (step_reg == ST_PASS) ? ST_GRAY : step_t'(step_reg + 1'b1);
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_LAPC_A;
            inpos_reg     <= '0;
            pending_reg   <= '0;
            addr_reg      <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            border_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            tap_valid_reg <= 1'b0;
            tap_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            inpos_reg     <= inpos_next;
            pending_reg   <= pending_next;
            addr_reg      <= addr_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            border_reg    <= border_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            // Read data shows up in the cycle after its address
            tap_valid_reg <= (state_reg == S_FETCH) && (k_reg != FetchLast);
            tap_idx_reg   <= k_reg;
        end
    end

endmodule

`default_nettype wire

[src/gss_datapath.sv]
// Datapath: coefficient registers, window sums, shared multiplier and output word register.
`default_nettype none

module gss_datapath import gss_pkg::*; #(
    parameter int VALUE_FRACTION_BITS = VALUE_FRACTION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire cmd_t        cmd,
    input  wire logic [15:0] a_tap,
    input  wire logic [15:0] b_tap,
    output logic      [15:0] a_out,
    output logic      [15:0] b_out,
    output logic      [7:0]  gray_level,
    output logic             last_of_frame
);

    localparam int F        = VALUE_FRACTION_BITS;
    localparam int AbbDown  = (F >= 14) ? F - 14 : 0;
    localparam int AbbUp    = (F < 14) ? 14 - F : 0;
    localparam logic signed [25:0] ValueOne = 26'sd1 <<< F;
    localparam logic signed [63:0] CapV =
        (F < 16) ? (64'sd1 <<< F) : 64'sd65535;

    // Coefficients
    logic signed [15:0] cw_reg, cc_reg, dw_reg;
    logic [14:0]        da_reg, db_reg, f_reg, k_reg, dt_reg;

    // Window summary per component
    logic [15:0] a_ctr_reg, b_ctr_reg;
    logic [17:0] a_card_reg, a_diag_reg, b_card_reg, b_diag_reg;

    // Arithmetic state
    logic signed [63:0] acc_reg, acc_next;
    logic [23:0]        lo_reg, lo_next;
    logic signed [47:0] dif_a_reg, dif_a_next;
    logic signed [47:0] dif_b_reg, dif_b_next;
    logic signed [47:0] abb_reg, abb_next;
    logic signed [47:0] feed_reg, feed_next;
    logic signed [47:0] kill_reg, kill_next;
    logic signed [47:0] d_reg, d_next;
    logic [15:0]        na_reg, na_next;
    logic [15:0]        nb_reg, nb_next;
    logic [7:0]         gray_reg, gray_next;

    logic signed [25:0] mx, my;
    logic signed [51:0] prod;
    logic signed [63:0] prod_ext;
    logic               mul_on, mul_acc, mul_shl;
    logic signed [63:0] new_a, new_b;
    logic signed [17:0] gdiff;
    logic signed [25:0] gscaled;

    function automatic logic [15:0] sat_value(input logic signed [63:0] v);
        logic [15:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > CapV)
        begin
            r = 16'(CapV);
        end
        else
        begin
            r = 16'(v);
        end
        return r;
    endfunction

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= CENTER_RESET;
            cc_reg <= CARDINAL_RESET;
            dw_reg <= DIAGONAL_RESET;
            da_reg <= DIFF_A_RESET;
            db_reg <= DIFF_B_RESET;
            f_reg  <= FEED_RESET;
            k_reg  <= KILL_RESET;
            dt_reg <= DT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CENTER:    cw_reg <= cfg_data;
                REG_CARDINAL:  cc_reg <= cfg_data;
                REG_DIAGONAL:  dw_reg <= cfg_data;
                REG_DIFF_A:    da_reg <= cfg_data[14:0];
                REG_DIFF_B:    db_reg <= cfg_data[14:0];
                REG_FEED:      f_reg  <= cfg_data[14:0];
                REG_KILL:      k_reg  <= cfg_data[14:0];
                REG_TIME_STEP: dt_reg <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // Collect center, edge and corner sums as the taps arrive
    always_ff @(posedge clk)
    begin
        if (cmd.tap_valid)
        begin
            if (cmd.tap_idx == 4'd4)
            begin
                a_ctr_reg <= a_tap;
                b_ctr_reg <= b_tap;
            end
            else if (cmd.tap_idx[0])
            begin
                a_card_reg <= (cmd.tap_idx == 4'd1) ? 18'(a_tap) : a_card_reg + 18'(a_tap);
                b_card_reg <= (cmd.tap_idx == 4'd1) ? 18'(b_tap) : b_card_reg + 18'(b_tap);
            end
            else
            begin
                a_diag_reg <= (cmd.tap_idx == 4'd0) ? 18'(a_tap) : a_diag_reg + 18'(a_tap);
                b_diag_reg <= (cmd.tap_idx == 4'd0) ? 18'(b_tap) : b_diag_reg + 18'(b_tap);
            end
        end
    end

    // Select multiplier operands per step
    always_comb
    begin
        mx      = '0;
        my      = '0;
        mul_on  = 1'b0;
        mul_acc = 1'b0;
        mul_shl = 1'b0;
        case (cmd.step) inside
            ST_LAPC_A: begin mx = 26'(cw_reg); my = signed'(26'(a_ctr_reg)); mul_on = 1'b1; end
            ST_LAPE_A: begin mx = 26'(cc_reg); my = signed'(26'(a_card_reg));
                             mul_on = 1'b1; mul_acc = 1'b1; end
            ST_LAPD_A: begin mx = 26'(dw_reg); my = signed'(26'(a_diag_reg));
                             mul_on = 1'b1; mul_acc = 1'b1; end
            ST_DIFH_A: begin mx = signed'(26'(da_reg)); my = 26'(acc_reg >>> 24);
                             mul_on = 1'b1; mul_shl = 1'b1; end
            ST_DIFL_A: begin mx = signed'(26'(da_reg)); my = signed'(26'(lo_reg));
                             mul_on = 1'b1; mul_acc = 1'b1; end
            ST_LAPC_B: begin mx = 26'(cw_reg); my = signed'(26'(b_ctr_reg)); mul_on = 1'b1; end
            ST_LAPE_B: begin mx = 26'(cc_reg); my = signed'(26'(b_card_reg));
                             mul_on = 1'b1; mul_acc = 1'b1; end
            ST_LAPD_B: begin mx = 26'(dw_reg); my = signed'(26'(b_diag_reg));
                             mul_on = 1'b1; mul_acc = 1'b1; end
            ST_DIFH_B: begin mx = signed'(26'(db_reg)); my = 26'(acc_reg >>> 24);
                             mul_on = 1'b1; mul_shl = 1'b1; end
            ST_DIFL_B: begin mx = signed'(26'(db_reg)); my = signed'(26'(lo_reg));
                             mul_on = 1'b1; mul_acc = 1'b1; end
            ST_AB:     begin mx = signed'(26'(a_ctr_reg)); my = signed'(26'(b_ctr_reg));
                             mul_on = 1'b1; end
            ST_ABB:    begin mx = 26'(acc_reg >>> F); my = signed'(26'(b_ctr_reg));
                             mul_on = 1'b1; end
            ST_FEED:   begin mx = signed'(26'(f_reg)); my = ValueOne - signed'(26'(a_ctr_reg));
                             mul_on = 1'b1; end
            ST_KILL:   begin mx = signed'(26'(k_reg) + 26'(f_reg));
                             my = signed'(26'(b_ctr_reg)); mul_on = 1'b1; end
            ST_TAH, ST_TBH:
            begin
                mx = signed'(26'(dt_reg)); my = 26'(d_reg >>> 24);
                mul_on = 1'b1; mul_shl = 1'b1;
            end
            ST_TAL, ST_TBL:
            begin
                mx = signed'(26'(dt_reg)); my = signed'(26'(lo_reg));
                mul_on = 1'b1; mul_acc = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign prod     = mx * my;
    assign prod_ext = mul_shl ? (64'(prod) <<< 24) : 64'(prod);

    // Step results
    always_comb
    begin
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        dif_a_next = dif_a_reg;
        dif_b_next = dif_b_reg;
        abb_next   = abb_reg;
        feed_next  = feed_reg;
        kill_next  = kill_reg;
        d_next     = d_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        gray_next  = gray_reg;

        new_a   = signed'(64'(a_ctr_reg)) + (acc_reg >>> 28);
        new_b   = signed'(64'(b_ctr_reg)) + (acc_reg >>> 28);
        gdiff   = signed'(18'(na_reg)) - signed'(18'(nb_reg));
        gscaled = ((26'(gdiff) <<< 8) - 26'(gdiff)) >>> F;

        if (cmd.calc)
        begin
            if (mul_on)
            begin
                acc_next = (mul_acc ? acc_reg : 64'sd0) + prod_ext;
            end
            case (cmd.step) inside
                ST_DIFH_A, ST_DIFH_B: lo_next = acc_reg[23:0];
                ST_DIFS_A: dif_a_next = 48'(acc_reg >>> 14);
                ST_DIFS_B: dif_b_next = 48'(acc_reg >>> 14);
                ST_FEED:   abb_next   = 48'((acc_reg >>> AbbDown) <<< AbbUp);
                ST_KILL:   feed_next  = 48'(acc_reg);
                ST_DA:
                begin
                    kill_next = 48'(acc_reg);
                    d_next    = dif_a_reg - abb_reg + feed_reg;
                end
                ST_TAH, ST_TBH: lo_next = d_reg[23:0];
                ST_NA:     na_next = sat_value(new_a);
                ST_DB:     d_next  = dif_b_reg + abb_reg - kill_reg;
                ST_NB:     nb_next = sat_value(new_b);
                ST_PASS:
                begin
                    na_next = a_ctr_reg;
                    nb_next = b_ctr_reg;
                end
                ST_GRAY:
                begin
                    if (gscaled < 0)
                    begin
                        gray_next = '0;
                    end
                    else if (gscaled > 26'sd255)
                    begin
                        gray_next = 8'd255;
                    end
                    else
                    begin
                        gray_next = 8'(gscaled);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold arithmetic state and the output word
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
        dif_a_reg <= dif_a_next;
        dif_b_reg <= dif_b_next;
        abb_reg   <= abb_next;
        feed_reg  <= feed_next;
        kill_reg  <= kill_next;
        d_reg     <= d_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        gray_reg  <= gray_next;
        if (cmd.load_out)
        begin
            a_out         <= na_reg;
            b_out         <= nb_reg;
            gray_level    <= gray_reg;
            last_of_frame <= cmd.last;
        end
    end

endmodule

`default_nettype wire

[dv/gray_scott_stencil_step_tb.sv]
// Self-checking testbench of the Gray-Scott stencil engine with a scoreboard class.
`timescale 1ns / 100ps
`default_nettype none

module gray_scott_stencil_step_tb;
    import gss_pkg::*;

    localparam int GRID       = 256;
    localparam int FRAC       = 15;
    localparam int RING       = 2 * GRID + 3;
    localparam int FRAME      = GRID * GRID;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 60;

    typedef struct {
        logic [15:0] a_next;
        logic [15:0] b_next;
        logic [7:0]  shade;
        logic        frame_end;
    } cell_result_t;

    // Predicts the next generation of each lagged cell and checks the block's answers
    class stencil_scoreboard;
        longint     w_center, w_card, w_diag, dif_a, dif_b, feed, kill, dt;
        logic [15:0] a_ring [RING];
        logic [15:0] b_ring [RING];
        int         wr_slot, out_cell, held;
        cell_result_t awaited [$];
        int         errors, results_seen, interior_seen, drains_seen;

        function void set_reg(reg_idx_t idx, logic [15:0] val);
            case (idx)
                REG_CENTER:    w_center = longint'($signed(val));
                REG_CARDINAL:  w_card   = longint'($signed(val));
                REG_DIAGONAL:  w_diag   = longint'($signed(val));
                REG_DIFF_A:    dif_a    = longint'(val[14:0]);
                REG_DIFF_B:    dif_b    = longint'(val[14:0]);
                REG_FEED:      feed     = longint'(val[14:0]);
                REG_KILL:      kill     = longint'(val[14:0]);
                REG_TIME_STEP: dt       = longint'(val[14:0]);
                default: ;
            endcase
        endfunction

        function void clear();
            w_center = -16384; w_card = 3277; w_diag = 819;
            dif_a = 16384; dif_b = 8192; feed = 901; kill = 1016; dt = 16384;
            wr_slot = 0; out_cell = 0; held = 0;
            errors = 0; results_seen = 0; interior_seen = 0; drains_seen = 0;
        endfunction

        function longint laplace(longint v [9]);
            return w_center * v[4] + w_card * (v[1] + v[3] + v[5] + v[7])
                 + w_diag * (v[0] + v[2] + v[6] + v[8]);
        endfunction

        function longint saturate(longint v);
            if (v < 0) return 0;
            if (v > 32768) return 32768;
            return v;
        endfunction

        // Compute the result of the oldest held cell and queue it
        function void release_oldest();
            int head, row, col, slot;
            longint av [9];
            longint bv [9];
            longint a, b, na, nb, abb, da, db, g;
            cell_result_t r;
            head = (wr_slot + RING - held) % RING;
            row = out_cell / GRID;
            col = out_cell % GRID;
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                begin
                    slot = (head + RING + dr * GRID + dc) % RING;
                    av[(dr + 1) * 3 + dc + 1] = longint'(a_ring[slot]);
                    bv[(dr + 1) * 3 + dc + 1] = longint'(b_ring[slot]);
                end
            a = av[4];
            b = bv[4];
            if (row == 0 || row == GRID - 1 || col == 0 || col == GRID - 1)
            begin
                na = a;
                nb = b;
            end
            else
            begin
                interior_seen++;
                abb = (((a * b) >>> FRAC) * b) >>> (FRAC - 14);
                da = ((dif_a * laplace(av)) >>> 14) - abb + feed * (32768 - a);
                db = ((dif_b * laplace(bv)) >>> 14) + abb - (kill + feed) * b;
                na = saturate(a + ((da * dt) >>> 28));
                nb = saturate(b + ((db * dt) >>> 28));
            end
            g = ((na - nb) * 255) >>> FRAC;
            if (g < 0) g = 0;
            if (g > 255) g = 255;
            r.a_next = na[15:0];
            r.b_next = nb[15:0];
            r.shade = g[7:0];
            r.frame_end = (out_cell == FRAME - 1);
            awaited.push_back(r);
            out_cell = (out_cell + 1) % FRAME;
            held--;
        endfunction

        function void note_word(logic drain, logic [15:0] a, logic [15:0] b);
            if (drain == MODE_DRAIN)
            begin
                drains_seen++;
                if (held > 0) release_oldest();
            end
            else
            begin
                a_ring[wr_slot] = a;
                b_ring[wr_slot] = b;
                wr_slot = (wr_slot + 1) % RING;
                if (held < RING) held++;
                if (held > GRID + 1) release_oldest();
            end
        endfunction

        function void check_result(logic [15:0] a, logic [15:0] b, logic [7:0] g, logic l);
            cell_result_t e;
            results_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result a=%0d b=%0d gray=%0d last=%0b",
                             a, b, g, l);
                return;
            end
            e = awaited.pop_front();
            if (a !== e.a_next || b !== e.b_next || g !== e.shade || l !== e.frame_end)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d exp a=%0d b=%0d gray=%0d last=%0b, ",
                              "got a=%0d b=%0d gray=%0d last=%0b"},
                             results_seen, e.a_next, e.b_next, e.shade, e.frame_end,
                             a, b, g, l);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [15:0] a_in;
    logic [15:0] b_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] a_out;
    logic [15:0] b_out;
    logic [7:0]  gray_level;
    logic        last_of_frame;

    stencil_scoreboard sb;
    logic        no_gaps;
    int          idle_cycles;
    int          cells_sent;

    gray_scott_stencil_step dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .a_in(a_in), .b_in(b_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .a_out(a_out), .b_out(b_out), .gray_level(gray_level),
        .last_of_frame(last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Note accepted words, check results, and watch for a stalled block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(mode, a_in, b_in);
            if (out_valid && out_ready)
                sb.check_result(a_out, b_out, gray_level, last_of_frame);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stall the result side at random
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_word(logic drain, logic [15:0] a, logic [15:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= drain;
        a_in <= a;
        b_in <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (drain != MODE_DRAIN) cells_sent++;
    endtask

    // Hold until every expected result is out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            sb.set_reg(reg_idx_t'(i), vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'd0;
        if (r < 10) return 16'd32768;
        if (r < 14) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 32768));
    endfunction

    // Random cells, with drains allowed once the line stores are full
    task automatic random_words(int count);
        logic drain;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            drain = (cells_sent >= RING && $urandom_range(0, 99) < 12) ?
                    MODE_DRAIN : ~MODE_DRAIN;
            send_word(drain, pick_value(), pick_value());
        end
    endtask

    initial
    begin
        logic [15:0] cfg [8];
        sb = new();
        sb.clear();
        no_gaps = 1'b0;
        idle_cycles = 0;
        cells_sent = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = 3'd0;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        mode = 1'b0;
        a_in = 16'd0;
        b_in = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: drain on an empty block, then field extremes on border cells
        send_word(MODE_DRAIN, 16'd0, 16'd0);
        send_word(MODE_DRAIN, 16'hFFFF, 16'hFFFF);
        send_word(~MODE_DRAIN, 16'd0, 16'd0);
        send_word(~MODE_DRAIN, 16'd32768, 16'd0);
        send_word(~MODE_DRAIN, 16'd0, 16'd32768);
        send_word(~MODE_DRAIN, 16'd32768, 16'd32768);
        send_word(~MODE_DRAIN, 16'hFFFF, 16'hFFFF);
        send_word(~MODE_DRAIN, 16'hFFFF, 16'd0);
        send_word(~MODE_DRAIN, 16'h5555, 16'hAAAA);
        send_word(~MODE_DRAIN, 16'hAAAA, 16'h5555);

        // Default coefficients: fill the line stores, pause once mid-stream
        random_words(390);
        wait_idle();
        random_words(220);
        // Early drains: answer cells before their lower neighbors arrive
        repeat (6) send_word(MODE_DRAIN, 16'hFFFF, 16'hFFFF);

        // Largest coefficients
        wait_idle();
        cfg = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        write_regs(cfg);
        random_words(100);

        // Smallest coefficients
        wait_idle();
        cfg = '{16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
        write_regs(cfg);
        random_words(100);

        // Classic pattern-forming set
        wait_idle();
        cfg = '{16'hC000, 16'd3277, 16'd819, 16'd16384, 16'd8192, 16'd901, 16'd1016, 16'd16384};
        write_regs(cfg);
        random_words(110);

        // Random coefficients
        wait_idle();
        for (int i = 0; i < 8; i++) cfg[i] = 16'($urandom_range(0, 65535));
        write_regs(cfg);
        random_words(110);

        wait_idle();
        $display("Covered %0d cells and %0d drains, %0d results checked (%0d interior).",
                 cells_sent, sb.drains_seen, sb.results_seen, sb.interior_seen);
        $display("Coefficient sets: reset, all maximum, all minimum, classic, random.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/gss_pkg.sv
src/gss_ram.sv
src/gss_ctrl.sv
src/gss_datapath.sv
src/gray_scott_stencil_step.sv
dv/gray_scott_stencil_step_tb.sv
